>>> hdl/ffvr_pkg.sv
package ffvr_pkg;

    localparam int IDX_W       = 24;
    localparam int LOCAL_W     = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_CORNER     = 1'b0;
    localparam logic OP_MESH_BREAK = 1'b1;

    // one command for the back end: a map clear or a triangle of three corners
    typedef struct packed {
        logic             clear;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_qwr;

endpackage

>>> hdl/ffvr_front.sv
module ffvr_front #(
    parameter int MAX_CORNERS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic [ffvr_pkg::IDX_W-1:0]   i_corner_index,
    input  logic                         i_face_start,
    input  logic                         i_q_full,
    output ffvr_pkg::t_qwr               o_wr
);
    import ffvr_pkg::*;

    localparam int CNT_W = $clog2(MAX_CORNERS + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_first;
    logic [IDX_W-1:0] r_prev;
    logic [CNT_W-1:0] w_cnt;
    logic             w_accept;
    logic             w_tri;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_cnt    = i_face_start ? '0 : r_count;
    // third and later corners of a face, below the corner limit
    assign w_tri    = (i_operation == OP_CORNER) && (w_cnt >= CNT_W'(2))
                      && (w_cnt < CNT_W'(MAX_CORNERS));

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (i_operation == OP_MESH_BREAK) begin
                n_count = '0;
            end else if (w_cnt < CNT_W'(MAX_CORNERS)) begin
                n_count = w_cnt + CNT_W'(1);
            end else begin
                n_count = w_cnt;
            end
        end
    end

    always_comb begin
        o_wr.push      = w_accept && ((i_operation == OP_MESH_BREAK) || w_tri);
        o_wr.cmd.clear = (i_operation == OP_MESH_BREAK);
        o_wr.cmd.a     = r_first;
        o_wr.cmd.b     = r_prev;
        o_wr.cmd.c     = i_corner_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_operation == OP_CORNER)) begin
            if (w_cnt == '0) begin
                r_first <= i_corner_index;
            end else if (w_cnt < CNT_W'(MAX_CORNERS)) begin
                r_prev <= i_corner_index;
            end
        end
    end

endmodule

>>> hdl/ffvr_queue.sv
module ffvr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffvr_pkg::t_qwr  i_wr,
    output logic            o_full,
    output logic            o_valid,
    output ffvr_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import ffvr_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr.push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_wr.push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

>>> hdl/ffvr_back.sv
module ffvr_back #(
    parameter int MAP_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  ffvr_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ffvr_pkg::LOCAL_W-1:0]   o_local_index,
    output logic [ffvr_pkg::IDX_W-1:0]     o_global_index,
    output logic                           o_is_new,
    output logic                           o_overflow,
    output logic                           o_last
);
    import ffvr_pkg::*;

    localparam int SLOT_W = $clog2(MAP_DEPTH);
    localparam int FILL_W = $clog2(MAP_DEPTH + 1);

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_addr;
    logic [FILL_W-1:0] n_addr;
    logic              r_pend;
    logic              n_pend;
    logic [1:0]        r_corner;
    logic [1:0]        n_corner;
    logic              r_out_valid;
    logic              n_out_valid;

    logic [IDX_W-1:0]  r_map [MAP_DEPTH];
    logic [IDX_W-1:0]  r_rdata;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [IDX_W-1:0]  r_key;
    t_cmd              r_tri;
    logic [SLOT_W-1:0] r_res_slot;
    logic              r_res_new;
    logic              r_res_ovf;

    logic [LOCAL_W-1:0] r_out_local;
    logic [IDX_W-1:0]   r_out_global;
    logic               r_out_new;
    logic               r_out_ovf;
    logic               r_out_last;

    logic              w_hit;
    logic              w_end;
    logic              w_full;
    logic              w_out_free;
    logic              w_map_we;
    logic [IDX_W-1:0]  w_next_key;

    // entry read last cycle matches the key being looked up
    assign w_hit      = r_pend && (r_rdata == r_key);
    // all filled entries compared without a match
    assign w_end      = !r_pend && (r_addr == r_fill);
    assign w_full     = (r_fill == FILL_W'(MAP_DEPTH));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_map_we   = (r_state == S_SCAN) && !w_hit && w_end && !w_full;

    always_comb begin
        case (n_corner)
            CORNER_A: w_next_key = r_tri.a;
            CORNER_B: w_next_key = r_tri.b;
            CORNER_C: w_next_key = r_tri.c;
            default:  w_next_key = r_tri.c;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_corner    = r_corner;
        n_out_valid = r_out_valid && i_stall;
        o_cmd_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.clear) begin
                        n_fill = '0;
                    end else begin
                        n_state  = S_SCAN;
                        n_corner = CORNER_A;
                        n_addr   = '0;
                        n_pend   = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_EMIT;
                end else if (w_end) begin
                    n_state = S_EMIT;
                    if (!w_full) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end else if (r_addr != r_fill) begin
                    n_pend = 1'b1;
                    n_addr = r_addr + FILL_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_corner == CORNER_C) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state  = S_SCAN;
                        n_corner = r_corner + 2'd1;
                        n_addr   = '0;
                        n_pend   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_corner    <= CORNER_A;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_corner    <= n_corner;
            r_out_valid <= n_out_valid;
        end
    end

    // key store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map[r_fill[SLOT_W-1:0]] <= r_key;
        end
        r_rdata <= r_map[r_addr[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_cmd_valid && !i_cmd.clear) begin
            r_tri <= i_cmd;
            r_key <= i_cmd.a;
        end
        if (r_state == S_SCAN) begin
            if (r_addr != r_fill) begin
                r_pend_slot <= r_addr[SLOT_W-1:0];
            end
            if (w_hit) begin
                r_res_slot <= r_pend_slot;
                r_res_new  <= 1'b0;
                r_res_ovf  <= 1'b0;
            end else if (w_end) begin
                r_res_slot <= w_full ? '0 : r_fill[SLOT_W-1:0];
                r_res_new  <= !w_full;
                r_res_ovf  <= w_full;
            end
        end
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out_local  <= LOCAL_W'(r_res_slot);
            r_out_global <= r_key;
            r_out_new    <= r_res_new;
            r_out_ovf    <= r_res_ovf;
            r_out_last   <= (r_corner == CORNER_C);
            r_key        <= w_next_key;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_local_index  = r_out_local;
    assign o_global_index = r_out_global;
    assign o_is_new       = r_out_new;
    assign o_overflow     = r_out_ovf;
    assign o_last         = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAP_DEPTH))
        else $error("map fill beyond depth");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_res_ovf) |-> w_full)
        else $error("overflow reported with free map slots");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_map_we |=> (r_fill == $past(r_fill) + FILL_W'(1)))
        else $error("insert without fill advance");

    a_new_or_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new && o_overflow))
        else $error("transfer flagged both new and overflow");

endmodule

>>> hdl/face_fan_vertex_remap_core.sv
// lookup: each triangle corner is looked up by scanning the key store one entry per cycle
// throughput: corners that close no triangle and mesh breaks transfer every cycle while the
//   two-entry command queue has room; a triangle holds the back end until its third corner is out
// reset: face and queue state cleared, map empty through its fill count, key store not cleared
module face_fan_vertex_remap_core #(
    parameter int MAP_DEPTH   = 1024,
    parameter int MAX_CORNERS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [ffvr_pkg::IDX_W-1:0]     i_corner_index,
    input  logic                           i_face_start,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ffvr_pkg::LOCAL_W-1:0]   o_local_index,
    output logic [ffvr_pkg::IDX_W-1:0]     o_global_index,
    output logic                           o_is_new,
    output logic                           o_overflow,
    output logic                           o_last
);
    import ffvr_pkg::*;

    t_qwr w_wr;
    t_cmd w_cmd;
    logic w_q_full;
    logic w_q_valid;
    logic w_q_pop;

    ffvr_front #(
        .MAX_CORNERS(MAX_CORNERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_corner_index (i_corner_index),
        .i_face_start   (i_face_start),
        .i_q_full       (w_q_full),
        .o_wr           (w_wr)
    );

    ffvr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd),
        .i_pop   (w_q_pop)
    );

    ffvr_back #(
        .MAP_DEPTH(MAP_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_local_index  (o_local_index),
        .o_global_index (o_global_index),
        .o_is_new       (o_is_new),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

endmodule
